// ===== src/fcsg_pkg.sv =====
package fcsg_pkg;

  // field widths
  localparam int COORD_BITS = 12;
  localparam int RAD_BITS   = 6;
  localparam int OUT_BITS   = 14;
  localparam int OX_BITS    = 7;
  localparam int OY_BITS    = 8;
  localparam int DEC_BITS   = 9;
  localparam int CMP_BITS   = 11;
  localparam int CNT_BITS   = 6;

  localparam logic [RAD_BITS-1:0] MAX_RADIUS = RAD_BITS'(63);
  localparam logic [CNT_BITS-1:0] MAX_ITER   = CNT_BITS'(63);

  // microprogram addressing
  localparam int PROG_LEN = 2;
  localparam int PC_BITS  = $clog2(PROG_LEN);

  typedef logic [PC_BITS-1:0] pc_t;

  localparam pc_t STEP_WAIT = pc_t'(0);
  localparam pc_t STEP_RUN  = pc_t'(1);

  // jump conditions
  typedef enum logic [1:0] {
    COND_NONE   = 2'd0,
    COND_ALWAYS = 2'd1,
    COND_IDLE   = 2'd2,
    COND_MORE   = 2'd3
  } cond_e;

  // one microcode word
  typedef struct packed {
    logic  load;
    logic  emit;
    cond_e cond;
    pc_t   target;
  } uword_t;

  // datapath controls from the sequencer
  typedef struct packed {
    logic load;
    logic emit;
  } ctrl_t;

  // datapath flags back to the sequencer
  typedef struct packed {
    logic last;
  } status_t;

  // control store: wait for a circle, then one span item per step
  function automatic uword_t ucode(pc_t addr);
    uword_t w;
    case (addr)
      STEP_WAIT: w = '{load: 1'b1, emit: 1'b0, cond: COND_IDLE, target: STEP_WAIT};
      STEP_RUN:  w = '{load: 1'b0, emit: 1'b1, cond: COND_MORE, target: STEP_RUN};
      default:   w = '{load: 1'b0, emit: 1'b0, cond: COND_ALWAYS, target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== src/filled_circle_span_generator_top.sv =====
// Filled circle span generator.
// A circle (center_x_i, center_y_i, radius_i) is taken at a rising edge where
// start is high and busy is low. The block then emits one item per cycle, each
// holding four horizontal spans: two wide rows at centre y +/- x offset and two
// narrow rows at centre y +/- y offset, with the matching left and right ends.
// valid_o marks each item for exactly one cycle; last_o flags the final one.
// Each circle is loaded into the loop registers at the accepting edge; every item
// then passes through the item output register, which drives valid_o.
// Throughput: a circle of radius r yields at most r + 1 items (about 0.71 r + 1
// in practice) at one per cycle; after the last one the sequencer passes its wait
// step before it can take a new circle. The rate is set by the microcoded
// sequencer, whose run step performs one decision update per cycle.
// busy stays high from the accepting edge until the cycle that shows the last
// item, and start is ignored meanwhile.
// The receiver cannot stall: items must be taken when valid_o is high.
// Reset returns the sequencer to its wait step and clears the strobe.
module filled_circle_span_generator_top
  import fcsg_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [COORD_BITS-1:0]      center_x_i,
  input  logic [COORD_BITS-1:0]      center_y_i,
  input  logic [RAD_BITS-1:0]        radius_i,
  output logic                       valid_o,
  output logic signed [OUT_BITS-1:0] wide_left_o,
  output logic signed [OUT_BITS-1:0] wide_right_o,
  output logic signed [OUT_BITS-1:0] narrow_left_o,
  output logic signed [OUT_BITS-1:0] narrow_right_o,
  output logic signed [OUT_BITS-1:0] row_wide_below_o,
  output logic signed [OUT_BITS-1:0] row_narrow_below_o,
  output logic signed [OUT_BITS-1:0] row_narrow_above_o,
  output logic signed [OUT_BITS-1:0] row_wide_above_o,
  output logic                       last_o
);

  ctrl_t   ctrl;
  status_t status;

  // control sequencer
  fcsg_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (busy)
  );

  // span datapath
  fcsg_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctrl_i             (ctrl),
    .center_x_i         (center_x_i),
    .center_y_i         (center_y_i),
    .radius_i           (radius_i),
    .status_o           (status),
    .valid_o            (valid_o),
    .wide_left_o        (wide_left_o),
    .wide_right_o       (wide_right_o),
    .narrow_left_o      (narrow_left_o),
    .narrow_right_o     (narrow_right_o),
    .row_wide_below_o   (row_wide_below_o),
    .row_narrow_below_o (row_narrow_below_o),
    .row_narrow_above_o (row_narrow_above_o),
    .row_wide_above_o   (row_wide_above_o),
    .last_o             (last_o)
  );

  // busy drops only with the final item of a circle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (valid_o && last_o))
    else $error("busy dropped without last item");

  // the final item leaves the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> !busy)
    else $error("still busy after last item");

  // an accepted circle makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("circle accepted but not busy");

  // items only follow busy cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy))
    else $error("item while idle");

endmodule

// ===== src/fcsg_seq.sv =====
module fcsg_seq
  import fcsg_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  status_t status_i,
  output ctrl_t   ctrl_o,
  output logic    busy_o
);

  pc_t    pc_q, pc_d;
  uword_t word;
  logic   take;

  // fetch the control word
  assign word = ucode(pc_q);

  // jump condition
  always_comb begin
    case (word.cond)
      COND_NONE:   take = 1'b0;
      COND_ALWAYS: take = 1'b1;
      COND_IDLE:   take = ~start;
      COND_MORE:   take = ~status_i.last;
      default:     take = 1'b0;
    endcase
  end

  // next address: jump target or fall through (the last step falls back to the start)
  assign pc_d = take ? word.target : pc_t'(pc_q + pc_t'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  // datapath controls
  assign ctrl_o.load = word.load & start;
  assign ctrl_o.emit = word.emit;
  assign busy_o      = (pc_q != STEP_WAIT);

endmodule

// ===== src/fcsg_dp.sv =====
module fcsg_dp
  import fcsg_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ctrl_t                      ctrl_i,
  input  logic [COORD_BITS-1:0]      center_x_i,
  input  logic [COORD_BITS-1:0]      center_y_i,
  input  logic [RAD_BITS-1:0]        radius_i,
  output status_t                    status_o,
  output logic                       valid_o,
  output logic signed [OUT_BITS-1:0] wide_left_o,
  output logic signed [OUT_BITS-1:0] wide_right_o,
  output logic signed [OUT_BITS-1:0] narrow_left_o,
  output logic signed [OUT_BITS-1:0] narrow_right_o,
  output logic signed [OUT_BITS-1:0] row_wide_below_o,
  output logic signed [OUT_BITS-1:0] row_narrow_below_o,
  output logic signed [OUT_BITS-1:0] row_narrow_above_o,
  output logic signed [OUT_BITS-1:0] row_wide_above_o,
  output logic                       last_o
);

  logic [COORD_BITS-1:0]     cx_q, cy_q;
  logic [RAD_BITS-1:0]       rad_q, rad_clamp;
  logic [OX_BITS-1:0]        ox_q, ox_d;
  logic signed [OY_BITS-1:0] oy_q, oy_d;
  logic signed [DEC_BITS-1:0] dec_q, dec_d;
  logic [CNT_BITS-1:0]       cnt_q;
  logic                      valid_q;

  logic signed [OUT_BITS-1:0] cx_w, cy_w, ox_w, oy_w;
  logic signed [CMP_BITS-1:0] dec_c, ox2_c, oy2_c, lim_c, sum_c;
  logic signed [CMP_BITS-1:0] ox_n, oy_n;
  logic                       last_d;

  // radius bound
  assign rad_clamp = (radius_i > MAX_RADIUS) ? MAX_RADIUS : radius_i;

  // operands widened for the decision test
  assign dec_c = CMP_BITS'(dec_q);
  assign ox2_c = signed'({{(CMP_BITS-OX_BITS-1){1'b0}}, ox_q, 1'b0});
  assign oy2_c = signed'({{(CMP_BITS-OY_BITS-1){oy_q[OY_BITS-1]}}, oy_q, 1'b0});
  assign lim_c = signed'({{(CMP_BITS-RAD_BITS-1){1'b0}}, rad_q, 1'b0}) - oy2_c;

  // one step of the Andres decision loop
  always_comb begin
    ox_d  = ox_q;
    oy_d  = oy_q;
    sum_c = dec_c;
    if (dec_c >= ox2_c) begin
      sum_c = dec_c - ox2_c - CMP_BITS'(1);
      ox_d  = OX_BITS'(ox_q + OX_BITS'(1));
    end else if (dec_c < lim_c) begin
      sum_c = dec_c + oy2_c - CMP_BITS'(1);
      oy_d  = OY_BITS'(oy_q - OY_BITS'(1));
    end else begin
      sum_c = dec_c + oy2_c - ox2_c - CMP_BITS'(2);
      oy_d  = OY_BITS'(oy_q - OY_BITS'(1));
      ox_d  = OX_BITS'(ox_q + OX_BITS'(1));
    end
    dec_d = sum_c[DEC_BITS-1:0];
  end

  // loop ends once the y offset drops below the x offset or the iteration limit is reached
  assign ox_n   = signed'({{(CMP_BITS-OX_BITS){1'b0}}, ox_d});
  assign oy_n   = CMP_BITS'(oy_d);
  assign last_d = (oy_n < ox_n) || (cnt_q == MAX_ITER);
  assign status_o.last = last_d;

  // loop registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cx_q  <= center_x_i;
      cy_q  <= center_y_i;
      rad_q <= rad_clamp;
      ox_q  <= '0;
      oy_q  <= OY_BITS'(rad_clamp);
      dec_q <= DEC_BITS'(rad_clamp) - DEC_BITS'(1);
      cnt_q <= '0;
    end else if (ctrl_i.emit) begin
      ox_q  <= ox_d;
      oy_q  <= oy_d;
      dec_q <= dec_d;
      cnt_q <= CNT_BITS'(cnt_q + CNT_BITS'(1));
    end
  end

  // span ends for the current offsets
  assign cx_w = signed'({{(OUT_BITS-COORD_BITS){1'b0}}, cx_q});
  assign cy_w = signed'({{(OUT_BITS-COORD_BITS){1'b0}}, cy_q});
  assign ox_w = signed'({{(OUT_BITS-OX_BITS){1'b0}}, ox_q});
  assign oy_w = OUT_BITS'(oy_q);

  // item output register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      wide_left_o        <= cx_w - oy_w;
      wide_right_o       <= cx_w + oy_w;
      narrow_left_o      <= cx_w - ox_w;
      narrow_right_o     <= cx_w + ox_w;
      row_wide_below_o   <= cy_w + ox_w;
      row_narrow_below_o <= cy_w + oy_w;
      row_narrow_above_o <= cy_w - oy_w;
      row_wide_above_o   <= cy_w - ox_w;
      last_o             <= last_d;
    end
  end

  // item strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_i.emit;
    end
  end

  assign valid_o = valid_q;

  // a circle never runs past the iteration limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit && (cnt_q == MAX_ITER) |-> last_d)
    else $error("iteration limit passed without last");

  // loading and emitting never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.load && ctrl_i.emit))
    else $error("load during emit");

  // x offset stays within the radius
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit |-> ({1'b0, ox_q} <= {2'b0, rad_q}))
    else $error("x offset beyond radius");

endmodule
